// ===== src/fr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and fixed constants for the Fresnel reflectance pipeline.
// No dependencies; imported by the top level, fr_front, fr_back_pre, fr_back_post and the testbench.
package fr_pkg;

    localparam int DATA_W     = 16;
    localparam int SQ_W       = 2 * DATA_W;
    localparam int RATIO_BITS = 20;
    localparam int RATIO_Q_W  = RATIO_BITS + 2;
    localparam int RATIO_SQ_W = 2 * RATIO_Q_W;
    localparam int OUT_SHIFT  = 2 * RATIO_BITS - 14;
    localparam int FRONT_N    = 6;
    localparam int PRE_N      = 3;
    localparam int POST_N     = 2;

    localparam logic [DATA_W-1:0] OUT_ONE     = 16'h8000;
    localparam logic [DATA_W-1:0] OUTER_RESET = 16'd14746;

    typedef struct packed {
        logic zero;
        logic tir;
    } fr_front_flags_t;

    typedef struct packed {
        logic zero;
        logic tir;
        logic degen;
        logic sat_s;
    } fr_back_flags_t;

endpackage

// ===== src/fresnel_reflectance.sv =====
`timescale 1ns / 1ps
// Unpolarized Fresnel reflectance unit, top level.
// Depends on fr_pkg, fr_front, fr_div_cell, fr_sqrt_cell, fr_back_pre, fr_back_post.
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------------------
//  item    | item_valid / item_stall    | normal_x/y/z, incident_x/y/z, inner_index
//  result  | result_valid / result_stall| reflectance, total_internal, degenerate
//  config  | cfg_wr_en                  | cfg_wr_data (outer index n1)
//
// One item enters per cycle while item_stall is low. The pipeline holds 6 front
// stages, FRAC_BITS+1 divider cells for sinT2, FRAC_BITS+1 root cells for cosT,
// 3 Fresnel term stages, 22 cells in each of the two ratio dividers running side
// by side, and 2 stages for square, round and result.
// Each stage holds its item only while the stage behind it is full and stalled,
// so bubbles close up and new items are taken while a result waits.
// Reset clears all stage valids and loads the outer index with 0.9.
module fresnel_reflectance
    import fr_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [DATA_W-1:0]         cfg_wr_data,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic signed [DATA_W-1:0]  normal_x,
    input  logic signed [DATA_W-1:0]  normal_y,
    input  logic signed [DATA_W-1:0]  normal_z,
    input  logic signed [DATA_W-1:0]  incident_x,
    input  logic signed [DATA_W-1:0]  incident_y,
    input  logic signed [DATA_W-1:0]  incident_z,
    input  logic [DATA_W-1:0]         inner_index,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [DATA_W-1:0]         reflectance,
    output logic                      total_internal,
    output logic                      degenerate
);

    localparam int F         = FRAC_BITS;
    localparam int LHS_W     = F + SQ_W + 1;
    localparam int C_W       = F + 2;
    localparam int RT_W      = F + 1;
    localparam int V_W       = 2 * F + 1;
    localparam int NW        = F + 20;
    localparam int DV_W      = NW + RATIO_BITS;
    localparam int SIDE_W    = 2 * DATA_W + C_W + 2;
    localparam int ST_BASE   = FRONT_N;
    localparam int ST_N      = F + 1;
    localparam int SQ_BASE   = ST_BASE + ST_N;
    localparam int SQ_N      = F + 1;
    localparam int PRE_BASE  = SQ_BASE + SQ_N;
    localparam int RD_BASE   = PRE_BASE + PRE_N;
    localparam int RD_N      = RATIO_Q_W;
    localparam int POST_BASE = RD_BASE + RD_N;
    localparam int N         = POST_BASE + POST_N;
    localparam logic [RT_W-1:0] ONE_Q = RT_W'(1) << F;

    logic [DATA_W-1:0] outer_index_reg;
    logic [N-1:0]      valid_reg;
    logic [N-1:0]      valid_next;
    logic [N-1:0]      en;

    // ---- configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_index_reg <= OUTER_RESET;
        end
        else if (cfg_wr_en)
        begin
            outer_index_reg <= cfg_wr_data;
        end
    end

    // ---- stage advance: a stage loads when empty or when its successor moves
    assign en[N-1] = !valid_reg[N-1] || !result_stall;
    genvar gi;
    generate
        for (gi = 0; gi < N - 1; gi++)
        begin : g_en
            assign en[gi] = !valid_reg[gi] || en[gi+1];
        end
    endgenerate

    assign valid_next = {valid_reg[N-2:0], item_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= (valid_next & en) | (valid_reg & ~en);
        end
    end

    assign item_stall   = !en[0];
    assign result_valid = valid_reg[N-1];

    // ---- front: cosI, s, lhs, total internal reflection
    logic [LHS_W-1:0]    f_lhs;
    logic [SQ_W-1:0]     f_n2sq;
    logic [DATA_W-1:0]   f_n1, f_n2;
    logic signed [C_W-1:0] f_c;
    fr_front_flags_t     f_flags;

    fr_front #(.F(F)) u_front (
        .clk         (clk),
        .en          (en[FRONT_N-1:0]),
        .n1          (outer_index_reg),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .normal_z    (normal_z),
        .incident_x  (incident_x),
        .incident_y  (incident_y),
        .incident_z  (incident_z),
        .inner_index (inner_index),
        .lhs         (f_lhs),
        .n2sq        (f_n2sq),
        .n1_out      (f_n1),
        .n2_out      (f_n2),
        .c_out       (f_c),
        .flags       (f_flags)
    );

    // ---- sinT2 = lhs / n2^2, one quotient bit per cell
    logic [LHS_W-1:0]  st_rem  [0:ST_N];
    logic [SQ_W-1:0]   st_den  [0:ST_N];
    logic [RT_W-1:0]   st_q    [0:ST_N];
    logic [SIDE_W-1:0] st_side [0:ST_N];

    assign st_rem[0]  = f_lhs;
    assign st_den[0]  = f_n2sq;
    assign st_q[0]    = '0;
    assign st_side[0] = {f_n1, f_n2, f_c, f_flags};

    generate
        for (gi = 0; gi < ST_N; gi++)
        begin : g_st
            fr_div_cell #(
                .REM_W (LHS_W),
                .DEN_W (SQ_W),
                .Q_W   (RT_W),
                .BIT   (F - gi),
                .SIDE_W(SIDE_W)
            ) u_cell (
                .clk     (clk),
                .en      (en[ST_BASE+gi]),
                .rem_in  (st_rem[gi]),
                .den_in  (st_den[gi]),
                .q_in    (st_q[gi]),
                .side_in (st_side[gi]),
                .rem_out (st_rem[gi+1]),
                .den_out (st_den[gi+1]),
                .q_out   (st_q[gi+1]),
                .side_out(st_side[gi+1])
            );
        end
    endgenerate

    // ---- cosT = floor(sqrt((1 - sinT2) * 2^F)), one root bit per cell
    logic [RT_W-1:0]   st_cap;
    logic [V_W-1:0]    sq_rem  [0:SQ_N];
    logic [RT_W-1:0]   sq_res  [0:SQ_N];
    logic [SIDE_W-1:0] sq_side [0:SQ_N];

    assign st_cap     = (st_q[ST_N] > ONE_Q) ? ONE_Q : st_q[ST_N];
    assign sq_rem[0]  = V_W'(ONE_Q - st_cap) << F;
    assign sq_res[0]  = '0;
    assign sq_side[0] = st_side[ST_N];

    generate
        for (gi = 0; gi < SQ_N; gi++)
        begin : g_sq
            fr_sqrt_cell #(
                .REM_W (V_W),
                .RES_W (RT_W),
                .BIT   (F - gi),
                .SIDE_W(SIDE_W)
            ) u_cell (
                .clk     (clk),
                .en      (en[SQ_BASE+gi]),
                .rem_in  (sq_rem[gi]),
                .res_in  (sq_res[gi]),
                .side_in (sq_side[gi]),
                .rem_out (sq_rem[gi+1]),
                .res_out (sq_res[gi+1]),
                .side_out(sq_side[gi+1])
            );
        end
    endgenerate

    // ---- unpack the carried fields and form the Fresnel terms
    logic [DATA_W-1:0]     b_n1, b_n2;
    logic signed [C_W-1:0] b_c;
    fr_front_flags_t       b_flags;

    assign {b_n1, b_n2, b_c, b_flags} = sq_side[SQ_N];

    logic [DV_W-1:0]  p_dvs, p_dvp;
    logic [NW-1:0]    p_ds, p_dp;
    fr_back_flags_t   p_flags;
    logic             p_satp;

    fr_back_pre #(.F(F)) u_pre (
        .clk       (clk),
        .en        (en[PRE_BASE +: PRE_N]),
        .n1        (b_n1),
        .n2        (b_n2),
        .c         (b_c),
        .cos_t     (sq_res[SQ_N]),
        .flags_in  (b_flags),
        .dividend_s(p_dvs),
        .den_s     (p_ds),
        .dividend_p(p_dvp),
        .den_p     (p_dp),
        .flags_out (p_flags),
        .sat_p     (p_satp)
    );

    // ---- two ratio dividers side by side, one quotient bit per cell
    logic [DV_W-1:0]      rs_rem  [0:RD_N];
    logic [NW-1:0]        rs_den  [0:RD_N];
    logic [RATIO_Q_W-1:0] rs_q    [0:RD_N];
    fr_back_flags_t       rs_side [0:RD_N];
    logic [DV_W-1:0]      rp_rem  [0:RD_N];
    logic [NW-1:0]        rp_den  [0:RD_N];
    logic [RATIO_Q_W-1:0] rp_q    [0:RD_N];
    logic                 rp_side [0:RD_N];

    assign rs_rem[0]  = p_dvs;
    assign rs_den[0]  = p_ds;
    assign rs_q[0]    = '0;
    assign rs_side[0] = p_flags;
    assign rp_rem[0]  = p_dvp;
    assign rp_den[0]  = p_dp;
    assign rp_q[0]    = '0;
    assign rp_side[0] = p_satp;

    generate
        for (gi = 0; gi < RD_N; gi++)
        begin : g_rd
            fr_div_cell #(
                .REM_W (DV_W),
                .DEN_W (NW),
                .Q_W   (RATIO_Q_W),
                .BIT   (RATIO_Q_W - 1 - gi),
                .SIDE_W($bits(fr_back_flags_t))
            ) u_cell_s (
                .clk     (clk),
                .en      (en[RD_BASE+gi]),
                .rem_in  (rs_rem[gi]),
                .den_in  (rs_den[gi]),
                .q_in    (rs_q[gi]),
                .side_in (rs_side[gi]),
                .rem_out (rs_rem[gi+1]),
                .den_out (rs_den[gi+1]),
                .q_out   (rs_q[gi+1]),
                .side_out(rs_side[gi+1])
            );

            fr_div_cell #(
                .REM_W (DV_W),
                .DEN_W (NW),
                .Q_W   (RATIO_Q_W),
                .BIT   (RATIO_Q_W - 1 - gi),
                .SIDE_W(1)
            ) u_cell_p (
                .clk     (clk),
                .en      (en[RD_BASE+gi]),
                .rem_in  (rp_rem[gi]),
                .den_in  (rp_den[gi]),
                .q_in    (rp_q[gi]),
                .side_in (rp_side[gi]),
                .rem_out (rp_rem[gi+1]),
                .den_out (rp_den[gi+1]),
                .q_out   (rp_q[gi+1]),
                .side_out(rp_side[gi+1])
            );
        end
    endgenerate

    // ---- square, average, round and hold the result
    fr_back_post u_post (
        .clk           (clk),
        .en            (en[POST_BASE +: POST_N]),
        .q_s           (rs_q[RD_N]),
        .q_p           (rp_q[RD_N]),
        .flags_in      (rs_side[RD_N]),
        .sat_p         (rp_side[RD_N]),
        .reflectance   (reflectance),
        .total_internal(total_internal),
        .degenerate    (degenerate)
    );

endmodule

// ===== src/fr_div_cell.sv =====
`timescale 1ns / 1ps
// One restoring-division cell: resolves a single quotient bit per cycle while en is high.
// Uses no package items; chained by the top level.
module fr_div_cell #(
    parameter int REM_W  = 48,
    parameter int DEN_W  = 32,
    parameter int Q_W    = 16,
    parameter int BIT    = 0,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              en,
    input  logic [REM_W-1:0]  rem_in,
    input  logic [DEN_W-1:0]  den_in,
    input  logic [Q_W-1:0]    q_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic [REM_W-1:0]  rem_out,
    output logic [DEN_W-1:0]  den_out,
    output logic [Q_W-1:0]    q_out,
    output logic [SIDE_W-1:0] side_out
);

    localparam int CMP_W = (REM_W > DEN_W + BIT) ? REM_W : DEN_W + BIT;

    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] trial;
    logic             fits;
    logic [REM_W-1:0] rem_next;
    logic [Q_W-1:0]   q_next;

    assign rem_ext  = CMP_W'(rem_in);
    assign trial    = CMP_W'(den_in) << BIT;
    assign fits     = rem_ext >= trial;
    assign rem_next = fits ? REM_W'(rem_ext - trial) : rem_in;
    assign q_next   = fits ? (q_in | (Q_W'(1) << BIT)) : q_in;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out  <= rem_next;
            den_out  <= den_in;
            q_out    <= q_next;
            side_out <= side_in;
        end
    end

endmodule

// ===== src/fr_sqrt_cell.sv =====
`timescale 1ns / 1ps
// One integer square-root cell: decides a single root bit per cycle while en is high.
// Uses no package items; chained by the top level.
module fr_sqrt_cell #(
    parameter int REM_W  = 29,
    parameter int RES_W  = 15,
    parameter int BIT    = 0,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              en,
    input  logic [REM_W-1:0]  rem_in,
    input  logic [RES_W-1:0]  res_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic [REM_W-1:0]  rem_out,
    output logic [RES_W-1:0]  res_out,
    output logic [SIDE_W-1:0] side_out
);

    localparam int TRY_W = RES_W + BIT + 2;
    localparam int CMP_W = (TRY_W > REM_W) ? TRY_W : REM_W;

    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] trial;
    logic             fits;

    // trial = 2*res*2^BIT + 2^(2*BIT), with res holding only the bits above BIT
    assign rem_ext = CMP_W'(rem_in);
    assign trial   = (CMP_W'(res_in) << (BIT + 1)) + (CMP_W'(1) << (2 * BIT));
    assign fits    = rem_ext >= trial;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out  <= fits ? REM_W'(rem_ext - trial) : rem_in;
            res_out  <= fits ? (res_in | (RES_W'(1) << BIT)) : res_in;
            side_out <= side_in;
        end
    end

endmodule

// ===== src/fr_front.sv =====
`timescale 1ns / 1ps
// Front stages: dot product, clamp and round of cosI, 1 - cosI^2, n1^2 * s,
// and the total internal reflection test. Depends on fr_pkg.
module fr_front
    import fr_pkg::*;
#(
    parameter int F = 14
) (
    input  logic                      clk,
    input  logic [FRONT_N-1:0]        en,
    input  logic [DATA_W-1:0]         n1,
    input  logic signed [DATA_W-1:0]  normal_x,
    input  logic signed [DATA_W-1:0]  normal_y,
    input  logic signed [DATA_W-1:0]  normal_z,
    input  logic signed [DATA_W-1:0]  incident_x,
    input  logic signed [DATA_W-1:0]  incident_y,
    input  logic signed [DATA_W-1:0]  incident_z,
    input  logic [DATA_W-1:0]         inner_index,
    output logic [F+SQ_W:0]           lhs,
    output logic [SQ_W-1:0]           n2sq,
    output logic [DATA_W-1:0]         n1_out,
    output logic [DATA_W-1:0]         n2_out,
    output logic signed [F+1:0]       c_out,
    output fr_front_flags_t           flags
);

    localparam int DW    = (2 * F + 2 > 35) ? 2 * F + 2 : 35;
    localparam int SW    = 2 * F + 2;
    localparam int LHS_W = F + SQ_W + 1;
    localparam logic [DW-1:0] LIM    = DW'(1) << (2 * F);
    localparam logic [DW-1:0] HALF_D = DW'(1) << (F - 1);
    localparam logic [SW-1:0] LIM_S  = SW'(1) << (2 * F);
    localparam logic [SW-1:0] HALF_S = SW'(1) << (F - 1);

    // stage 0
    logic signed [SQ_W-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [SQ_W-1:0] p0_next, p1_next, p2_next;
    logic [SQ_W-1:0]        s0_n1sq_reg, s0_n2sq_reg;
    logic [DATA_W-1:0]      s0_n1_reg, s0_n2_reg;
    logic                   s0_zero_reg;
    // stage 1
    logic signed [DW-1:0]   d_reg, d_next;
    logic [SQ_W-1:0]        s1_n1sq_reg, s1_n2sq_reg;
    logic [DATA_W-1:0]      s1_n1_reg, s1_n2_reg;
    logic                   s1_zero_reg;
    // stage 2
    logic [DW-1:0]          abs_d, abs_c, rnd;
    logic [F:0]             mag;
    logic signed [F+1:0]    c2_reg, c2_next;
    logic [SQ_W-1:0]        s2_n1sq_reg, s2_n2sq_reg;
    logic [DATA_W-1:0]      s2_n1_reg, s2_n2_reg;
    logic                   s2_zero_reg;
    // stage 3
    logic [F:0]             cabs;
    logic [SW-1:0]          csq, s_full;
    logic [F:0]             s3_reg, s3_next;
    logic signed [F+1:0]    c3_reg;
    logic [SQ_W-1:0]        s3_n1sq_reg, s3_n2sq_reg;
    logic [DATA_W-1:0]      s3_n1_reg, s3_n2_reg;
    logic                   s3_zero_reg;
    // stage 4
    logic [LHS_W-1:0]       lhs4_reg, lhs4_next;
    logic signed [F+1:0]    c4_reg;
    logic [SQ_W-1:0]        s4_n2sq_reg;
    logic [DATA_W-1:0]      s4_n1_reg, s4_n2_reg;
    logic                   s4_zero_reg;
    // stage 5
    logic                   tir_next;
    logic [LHS_W-1:0]       lhs5_reg;
    logic signed [F+1:0]    c5_reg;
    logic [SQ_W-1:0]        s5_n2sq_reg;
    logic [DATA_W-1:0]      s5_n1_reg, s5_n2_reg;
    fr_front_flags_t        flags5_reg;

    assign p0_next = normal_x * incident_x;
    assign p1_next = normal_y * incident_y;
    assign p2_next = normal_z * incident_z;

    assign d_next = -(DW'(p0_reg) + DW'(p1_reg) + DW'(p2_reg));

    assign abs_d   = d_reg[DW-1] ? DW'(-d_reg) : DW'(d_reg);
    assign abs_c   = (abs_d > LIM) ? LIM : abs_d;
    assign rnd     = abs_c + HALF_D;
    assign mag     = (F+1)'(rnd >> F);
    assign c2_next = d_reg[DW-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    assign cabs    = c2_reg[F+1] ? (F+1)'(-c2_reg) : (F+1)'(c2_reg);
    assign csq     = SW'(cabs) * SW'(cabs);
    assign s_full  = LIM_S - csq + HALF_S;
    assign s3_next = (F+1)'(s_full >> F);

    assign lhs4_next = LHS_W'(s3_n1sq_reg) * LHS_W'(s3_reg);
    assign tir_next  = lhs4_reg > (LHS_W'(s4_n2sq_reg) << F);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p0_reg      <= p0_next;
            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
            s0_n1sq_reg <= SQ_W'(n1) * SQ_W'(n1);
            s0_n2sq_reg <= SQ_W'(inner_index) * SQ_W'(inner_index);
            s0_n1_reg   <= n1;
            s0_n2_reg   <= inner_index;
            s0_zero_reg <= inner_index == '0;
        end
        if (en[1])
        begin
            d_reg       <= d_next;
            s1_n1sq_reg <= s0_n1sq_reg;
            s1_n2sq_reg <= s0_n2sq_reg;
            s1_n1_reg   <= s0_n1_reg;
            s1_n2_reg   <= s0_n2_reg;
            s1_zero_reg <= s0_zero_reg;
        end
        if (en[2])
        begin
            c2_reg      <= c2_next;
            s2_n1sq_reg <= s1_n1sq_reg;
            s2_n2sq_reg <= s1_n2sq_reg;
            s2_n1_reg   <= s1_n1_reg;
            s2_n2_reg   <= s1_n2_reg;
            s2_zero_reg <= s1_zero_reg;
        end
        if (en[3])
        begin
            s3_reg      <= s3_next;
            c3_reg      <= c2_reg;
            s3_n1sq_reg <= s2_n1sq_reg;
            s3_n2sq_reg <= s2_n2sq_reg;
            s3_n1_reg   <= s2_n1_reg;
            s3_n2_reg   <= s2_n2_reg;
            s3_zero_reg <= s2_zero_reg;
        end
        if (en[4])
        begin
            lhs4_reg    <= lhs4_next;
            c4_reg      <= c3_reg;
            s4_n2sq_reg <= s3_n2sq_reg;
            s4_n1_reg   <= s3_n1_reg;
            s4_n2_reg   <= s3_n2_reg;
            s4_zero_reg <= s3_zero_reg;
        end
        if (en[5])
        begin
            lhs5_reg        <= lhs4_reg;
            c5_reg          <= c4_reg;
            s5_n2sq_reg     <= s4_n2sq_reg;
            s5_n1_reg       <= s4_n1_reg;
            s5_n2_reg       <= s4_n2_reg;
            flags5_reg.zero <= s4_zero_reg;
            flags5_reg.tir  <= tir_next;
        end
    end

    assign lhs    = lhs5_reg;
    assign n2sq   = s5_n2sq_reg;
    assign n1_out = s5_n1_reg;
    assign n2_out = s5_n2_reg;
    assign c_out  = c5_reg;
    assign flags  = flags5_reg;

endmodule

// ===== src/fr_back_pre.sv =====
`timescale 1ns / 1ps
// Fresnel numerators and denominators, zero-denominator and ratio-cap tests,
// and dividend setup for the ratio dividers. Depends on fr_pkg.
module fr_back_pre
    import fr_pkg::*;
#(
    parameter int F = 14
) (
    input  logic                  clk,
    input  logic [PRE_N-1:0]      en,
    input  logic [DATA_W-1:0]     n1,
    input  logic [DATA_W-1:0]     n2,
    input  logic signed [F+1:0]   c,
    input  logic [F:0]            cos_t,
    input  fr_front_flags_t       flags_in,
    output logic [F+RATIO_BITS+19:0] dividend_s,
    output logic [F+19:0]         den_s,
    output logic [F+RATIO_BITS+19:0] dividend_p,
    output logic [F+19:0]         den_p,
    output fr_back_flags_t        flags_out,
    output logic                  sat_p
);

    localparam int PW = F + 19;
    localparam int NW = PW + 1;
    localparam int DV = NW + RATIO_BITS;

    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [PW-1:0] n1_s, n2_s, c_s, cos_s;
    fr_front_flags_t      f1_reg, f2_reg;
    logic signed [NW-1:0] ns_reg, ds_reg, np_reg, dp_reg;
    logic [NW-1:0]        a_ns, a_ds, a_np, a_dp;
    logic [DV-1:0]        dvs_reg, dvp_reg;
    logic [NW-1:0]        ds3_reg, dp3_reg;
    fr_back_flags_t       f3_reg;
    logic                 satp3_reg;

    assign n1_s  = PW'($signed({1'b0, n1}));
    assign n2_s  = PW'($signed({1'b0, n2}));
    assign c_s   = PW'(c);
    assign cos_s = PW'($signed({1'b0, cos_t}));

    assign a_ns = ns_reg[NW-1] ? NW'(-ns_reg) : NW'(ns_reg);
    assign a_ds = ds_reg[NW-1] ? NW'(-ds_reg) : NW'(ds_reg);
    assign a_np = np_reg[NW-1] ? NW'(-np_reg) : NW'(np_reg);
    assign a_dp = dp_reg[NW-1] ? NW'(-dp_reg) : NW'(dp_reg);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pa_reg <= n1_s * c_s;
            pb_reg <= n2_s * cos_s;
            pc_reg <= n2_s * c_s;
            pd_reg <= n1_s * cos_s;
            f1_reg <= flags_in;
        end
        if (en[1])
        begin
            ns_reg <= NW'(pa_reg) - NW'(pb_reg);
            ds_reg <= NW'(pa_reg) + NW'(pb_reg);
            np_reg <= NW'(pc_reg) - NW'(pd_reg);
            dp_reg <= NW'(pc_reg) + NW'(pd_reg);
            f2_reg <= f1_reg;
        end
        if (en[2])
        begin
            dvs_reg      <= DV'(a_ns) << RATIO_BITS;
            dvp_reg      <= DV'(a_np) << RATIO_BITS;
            ds3_reg      <= a_ds;
            dp3_reg      <= a_dp;
            f3_reg.zero  <= f2_reg.zero;
            f3_reg.tir   <= f2_reg.tir;
            f3_reg.degen <= (ds_reg == '0) || (dp_reg == '0);
            // ratio of four or more always ends at the cap
            f3_reg.sat_s <= (NW+2)'(a_ns) >= ((NW+2)'(a_ds) << 2);
            satp3_reg    <= (NW+2)'(a_np) >= ((NW+2)'(a_dp) << 2);
        end
    end

    assign dividend_s = dvs_reg;
    assign dividend_p = dvp_reg;
    assign den_s      = ds3_reg;
    assign den_p      = dp3_reg;
    assign flags_out  = f3_reg;
    assign sat_p      = satp3_reg;

endmodule

// ===== src/fr_back_post.sv =====
`timescale 1ns / 1ps
// Ratio cap and square, average and rounding to Q1.15, flag priority and
// the result register. Depends on fr_pkg.
module fr_back_post
    import fr_pkg::*;
(
    input  logic                  clk,
    input  logic [POST_N-1:0]     en,
    input  logic [RATIO_Q_W-1:0]  q_s,
    input  logic [RATIO_Q_W-1:0]  q_p,
    input  fr_back_flags_t        flags_in,
    input  logic                  sat_p,
    output logic [DATA_W-1:0]     reflectance,
    output logic                  total_internal,
    output logic                  degenerate
);

    localparam logic [RATIO_Q_W-1:0] CAP = RATIO_Q_W'(2) << RATIO_BITS;
    localparam int SUM_W = RATIO_SQ_W + 1;
    localparam int RF_W  = SUM_W - OUT_SHIFT;

    logic [RATIO_Q_W-1:0]  r_s, r_p;
    logic [RATIO_SQ_W-1:0] sq_s_reg, sq_p_reg;
    fr_back_flags_t        f4_reg;
    logic [SUM_W-1:0]      sum;
    logic [RF_W-1:0]       refl;
    logic [DATA_W-1:0]     refl_sat;
    logic [DATA_W-1:0]     refl_next;
    logic                  tir_next, deg_next;
    logic [DATA_W-1:0]     refl_reg;
    logic                  tir_reg, deg_reg;

    assign r_s = (flags_in.sat_s || q_s > CAP) ? CAP : q_s;
    assign r_p = (sat_p || q_p > CAP) ? CAP : q_p;

    assign sum      = SUM_W'(sq_s_reg) + SUM_W'(sq_p_reg) + (SUM_W'(1) << (OUT_SHIFT - 1));
    assign refl     = RF_W'(sum >> OUT_SHIFT);
    assign refl_sat = (refl > RF_W'(OUT_ONE)) ? OUT_ONE : DATA_W'(refl);

    // zero index first, then total internal reflection, then zero denominator
    always_comb
    begin
        refl_next = OUT_ONE;
        tir_next  = 1'b0;
        deg_next  = 1'b0;
        if (f4_reg.zero)
        begin
            deg_next = 1'b1;
        end
        else if (f4_reg.tir)
        begin
            tir_next = 1'b1;
        end
        else if (f4_reg.degen)
        begin
            deg_next = 1'b1;
        end
        else
        begin
            refl_next = refl_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sq_s_reg <= RATIO_SQ_W'(r_s) * RATIO_SQ_W'(r_s);
            sq_p_reg <= RATIO_SQ_W'(r_p) * RATIO_SQ_W'(r_p);
            f4_reg   <= flags_in;
        end
        if (en[1])
        begin
            refl_reg <= refl_next;
            tir_reg  <= tir_next;
            deg_reg  <= deg_next;
        end
    end

    assign reflectance    = refl_reg;
    assign total_internal = tir_reg;
    assign degenerate     = deg_reg;

endmodule

// ===== tb/fresnel_reflectance_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Fresnel reflectance unit: drives random and
// directed items, predicts each result in fixed point and compares field by field.
// Depends on fr_pkg and fresnel_reflectance.
module fresnel_reflectance_tb
    import fr_pkg::*;
();

    localparam int FB       = 14;
    localparam int LATENCY  = 2 * FB + 35;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] nx, ny, nz, ix, iy, iz;
        logic [15:0]        n2;
    } ray_item_t;

    typedef struct packed {
        logic [15:0] refl;
        logic        tir;
        logic        degen;
    } refl_result_t;

    logic clk, rst_n;
    logic cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic item_valid, item_stall;
    ray_item_t cur;
    logic result_valid, result_stall;
    logic [15:0] reflectance;
    logic total_internal, degenerate;

    ray_item_t    pending_items[$];
    refl_result_t expected_refl[$];
    logic [15:0]  n1_model;

    int errors = 0;
    int n_results = 0, n_tir = 0, n_degen = 0;
    int idle_cycles = 0;
    bit quiet_mode = 0;
    bit drain_hold = 0;
    int hold_len = 0;
    bit hold_req = 0;
    bit in_taken = 0;

    fresnel_reflectance #(.FRAC_BITS(FB)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .item_valid(item_valid), .item_stall(item_stall),
        .normal_x(cur.nx), .normal_y(cur.ny), .normal_z(cur.nz),
        .incident_x(cur.ix), .incident_y(cur.iy), .incident_z(cur.iz),
        .inner_index(cur.n2),
        .result_valid(result_valid), .result_stall(result_stall),
        .reflectance(reflectance), .total_internal(total_internal),
        .degenerate(degenerate)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Square of |num/den| in Q40, ratio capped at 2.0.
    function automatic logic [63:0] ratio_square(longint num, longint den);
        logic [63:0] r;
        logic [63:0] an, ad;
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        r = (an << 20) / ad;
        if (r > (64'd2 << 20)) r = 64'd2 << 20;
        return r * r;
    endfunction

    function automatic refl_result_t fresnel_predict(ray_item_t it, logic [15:0] n1u);
        refl_result_t res;
        longint n1, n2, lim, d, c, cos_t, ns, ds, np, dp;
        logic [63:0] mag, s, lhs, rhs, st, sum, r;
        n1 = n1u;
        n2 = it.n2;
        lim = longint'(1) << (2 * FB);
        res = '{refl: OUT_ONE, tir: 1'b0, degen: 1'b0};
        if (n2 == 0)
        begin
            res.degen = 1'b1;
            return res;
        end
        d = -(longint'(it.nx) * it.ix + longint'(it.ny) * it.iy + longint'(it.nz) * it.iz);
        if (d > lim) d = lim;
        if (d < -lim) d = -lim;
        mag = ((d < 0 ? -d : d) + (1 << (FB - 1))) >> FB;
        c = d < 0 ? -longint'(mag) : longint'(mag);
        s = (lim - c * c + (1 << (FB - 1))) >> FB;
        lhs = (n1 * n1) * s;
        rhs = (n2 * n2) << FB;
        if (lhs > rhs)
        begin
            res.tir = 1'b1;
            return res;
        end
        st = lhs / (n2 * n2);
        if (st > (64'd1 << FB)) st = 64'd1 << FB;
        cos_t = isqrt(((64'd1 << FB) - st) << FB);
        ns = n1 * c - n2 * cos_t;
        ds = n1 * c + n2 * cos_t;
        np = n2 * c - n1 * cos_t;
        dp = n2 * c + n1 * cos_t;
        if (ds == 0 || dp == 0)
        begin
            res.degen = 1'b1;
            return res;
        end
        sum = ratio_square(ns, ds) + ratio_square(np, dp);
        r = (sum + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        if (r > OUT_ONE) r = OUT_ONE;
        res.refl = r[15:0];
        return res;
    endfunction

    // Input acceptance: predict the result at the edge that takes the item.
    always @(posedge clk)
    begin
        in_taken <= rst_n && item_valid && !item_stall;
        if (rst_n && item_valid && !item_stall)
            expected_refl = {expected_refl, fresnel_predict(cur, n1_model)};
    end

    // Driver: hold an offered item until taken, then present the next or idle.
    always @(negedge clk)
    begin
        if (in_taken)
            void'(pending_items.pop_front());
        if (item_valid && !in_taken)
        begin
            item_valid <= 1'b1;
        end
        else if (pending_items.size() != 0 && !drain_hold &&
                 (quiet_mode || $urandom_range(99) >= 9))
        begin
            item_valid <= 1'b1;
            cur <= pending_items[0];
        end
        else
            item_valid <= 1'b0;
    end

    // Receiver stall: a long hold when requested, otherwise random.
    always @(negedge clk)
    begin
        if (hold_req && hold_len == 0)
            hold_len <= 300;
        if (hold_len > 0)
        begin
            result_stall <= 1'b1;
            hold_len <= hold_len - 1;
            if (hold_len == 1) hold_req <= 1'b0;
        end
        else
            result_stall <= !quiet_mode && $urandom_range(99) < 9;
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        refl_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_refl.size() == 0)
            begin
                $display("%0t: unexpected result refl=%0d tir=%b degen=%b", $time,
                         reflectance, total_internal, degenerate);
                errors++;
            end
            else
            begin
                want = expected_refl.pop_front();
                n_results++;
                if (want.tir) n_tir++;
                if (want.degen) n_degen++;
                if (want.refl !== reflectance)
                begin
                    $display("%0t: reflectance expected %0d actual %0d", $time,
                             want.refl, reflectance);
                    errors++;
                end
                if (want.tir !== total_internal)
                begin
                    $display("%0t: total_internal expected %b actual %b", $time,
                             want.tir, total_internal);
                    errors++;
                end
                if (want.degen !== degenerate)
                begin
                    $display("%0t: degenerate expected %b actual %b", $time,
                             want.degen, degenerate);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("fresnel_reflectance_tb NOT OK");
            $finish;
        end
    end

    function automatic logic signed [15:0] rnd_comp();
        // Mostly near unit range; sometimes anything.
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'(int'($urandom_range(32768)) - 16384);
    endfunction

    function automatic ray_item_t rnd_ray();
        ray_item_t it;
        int u;
        it.nx = rnd_comp(); it.ny = rnd_comp(); it.nz = rnd_comp();
        it.ix = rnd_comp(); it.iy = rnd_comp(); it.iz = rnd_comp();
        u = $urandom_range(19);
        if (u == 0) it.n2 = 0;
        else if (u < 4) it.n2 = 16'($urandom);
        else it.n2 = 16'($urandom_range(32768, 12000));
        return it;
    endfunction

    function automatic ray_item_t mk(int nx, int ny, int nz, int ix, int iy, int iz, int n2);
        ray_item_t it;
        it = '{nx: 16'(nx), ny: 16'(ny), nz: 16'(nz), ix: 16'(ix), iy: 16'(iy),
               iz: 16'(iz), n2: 16'(n2)};
        return it;
    endfunction

    task automatic queue_ray(ray_item_t it);
        pending_items = {pending_items, it};
    endtask

    // Let the pipeline empty before touching the register.
    task automatic wait_drained();
        wait (pending_items.size() == 0 && !item_valid);
        wait (expected_refl.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_n1(logic [15:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        n1_model = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_random(int count);
        repeat (count) queue_ray(rnd_ray());
    endtask

    initial
    begin
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        item_valid = 0;
        result_stall = 0;
        cur = '0;
        n1_model = OUTER_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: head-on, grazing, backfacing, extremes, zero index, TIR.
        queue_ray(mk(0, 0, 16384, 0, 0, -16384, 24576));
        queue_ray(mk(0, 0, 16384, 16384, 0, 0, 24576));
        queue_ray(mk(0, 0, 16384, 0, 0, 16384, 24576));
        queue_ray(mk(0, 0, 16384, 0, 0, -16384, 0));
        queue_ray(mk(0, 0, 16384, 16000, 0, -3000, 8000));
        queue_ray(mk(-32768, -32768, -32768, -32768, -32768, -32768, 65535));
        queue_ray(mk(32767, 32767, 32767, -32768, -32768, -32768, 65535));
        queue_ray(mk(32767, -32768, 32767, 32767, -32768, 32767, 1));
        queue_ray(mk(0, 0, 0, 0, 0, 0, 16384));
        queue_ray(mk(0, 16384, 0, 11585, -11585, 0, 14746));
        queue_ray(mk(0, 16384, 0, 0, -16384, 0, 14746));
        queue_ray(mk(0, 0, 16384, 0, 1, -16384, 32768));
        queue_ray(mk(-1, 1, -1, 1, -1, 1, 65535));
        wait_drained();

        // Zero outer index: at grazing incidence the p numerator and denominator are zero.
        write_n1(16'd0);
        queue_ray(mk(0, 0, 16384, 0, 0, -16384, 24576));
        queue_ray(mk(0, 0, 16384, 16384, 0, 0, 24576));
        queue_random(20);
        wait_drained();

        write_n1(16'hFFFF);
        queue_random(60);
        wait_drained();

        // Long receiver hold with the sender streaming; no idling here.
        write_n1(OUTER_RESET);
        quiet_mode = 1;
        hold_req = 1;
        queue_random(150);
        wait_drained();
        quiet_mode = 0;

        write_n1(16'd24576);
        queue_random(100);
        // Sender pause until everything is back.
        wait (pending_items.size() == 0);
        drain_hold = 1;
        wait (expected_refl.size() == 0 && !item_valid);
        drain_hold = 0;
        write_n1(16'd1);
        queue_random(100);
        wait_drained();

        $display("covered %0d results: %0d total internal, %0d degenerate, n1 at 0/1/max/mid",
                 n_results, n_tir, n_degen);
        if (errors == 0)
            $display("fresnel_reflectance_tb OK");
        else
            $display("fresnel_reflectance_tb NOT OK");
        $finish;
    end
endmodule
